// ===== hdl/trw_pkg.sv =====
// Shared types and constants for the timestamp reorder window.
// Used by trw_cell and timestamp_reorder_window_top; no dependencies.
package trw_pkg;

    localparam int SEC_W     = 32;
    localparam int NSEC_W    = 30;
    localparam int OUT_PAY_W = 32;
    localparam int LEN_W     = 5;
    localparam int STATUS_W  = 2;

    localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_EMITTED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_HELD    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_CLEARED = 2'd3;

    typedef struct packed {
        logic load;
        logic full;
    } cell_ctrl_t;

endpackage

// ===== hdl/trw_cell.sv =====
// One slot of the sorted window: holds one entry, compares it with the new item
// and shifts to or from its neighbors. Depends on trw_pkg.
module trw_cell #(
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                       aclk,
    input  trw_pkg::cell_ctrl_t        ctrl,
    input  logic                       valid_i,
    input  logic                       g_below_i,
    input  logic                       valid_below_i,
    input  logic                       g_above_i,
    input  logic [trw_pkg::SEC_W-1:0]  new_sec_i,
    input  logic [trw_pkg::NSEC_W-1:0] new_nsec_i,
    input  logic [PAYLOAD_BITS-1:0]    new_pay_i,
    input  logic [trw_pkg::SEC_W-1:0]  up_sec_i,
    input  logic [trw_pkg::NSEC_W-1:0] up_nsec_i,
    input  logic [PAYLOAD_BITS-1:0]    up_pay_i,
    input  logic [trw_pkg::SEC_W-1:0]  dn_sec_i,
    input  logic [trw_pkg::NSEC_W-1:0] dn_nsec_i,
    input  logic [PAYLOAD_BITS-1:0]    dn_pay_i,
    output logic                       g_o,
    output logic [trw_pkg::SEC_W-1:0]  sec_o,
    output logic [trw_pkg::NSEC_W-1:0] nsec_o,
    output logic [PAYLOAD_BITS-1:0]    pay_o
);

    logic [trw_pkg::SEC_W-1:0]  sec_reg;
    logic [trw_pkg::NSEC_W-1:0] nsec_reg;
    logic [PAYLOAD_BITS-1:0]    pay_reg;
    logic                       ge;

    assign ge = (new_sec_i > sec_reg) || ((new_sec_i == sec_reg) && (new_nsec_i >= nsec_reg));
    assign g_o = ge && valid_i;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            if (ctrl.full) begin
                if (g_above_i) begin
                    sec_reg  <= up_sec_i;
                    nsec_reg <= up_nsec_i;
                    pay_reg  <= up_pay_i;
                end else if (g_o) begin
                    sec_reg  <= new_sec_i;
                    nsec_reg <= new_nsec_i;
                    pay_reg  <= new_pay_i;
                end
            end else begin
                if (g_below_i && !g_o) begin
                    sec_reg  <= new_sec_i;
                    nsec_reg <= new_nsec_i;
                    pay_reg  <= new_pay_i;
                end else if (!g_below_i && valid_below_i) begin
                    sec_reg  <= dn_sec_i;
                    nsec_reg <= dn_nsec_i;
                    pay_reg  <= dn_pay_i;
                end
            end
        end
    end

    assign sec_o  = sec_reg;
    assign nsec_o = nsec_reg;
    assign pay_o  = pay_reg;

endmodule

// ===== hdl/timestamp_reorder_window_top.sv =====
// Timestamp reorder window: top level with fill count, window length register
// and output register. Depends on trw_pkg and trw_cell.
//
// Takes one item per clock cycle whenever the result register is empty or being
// read in the same cycle; each item gives exactly one result in the next cycle.
// All DEPTH slots compare the new timestamp at once and shift in the same edge,
// so the critical path is one 62-bit compare per slot plus the shift mux.
// A clear item empties the window at once; no clearing pass is needed.
module timestamp_reorder_window_top #(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [trw_pkg::LEN_W-1:0]   cfg_wr_data,   // window_length
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [((trw_pkg::SEC_W + trw_pkg::NSEC_W + PAYLOAD_BITS + 7) / 8) * 8 - 1:0]
                                        s_tdata,       // ts_seconds, ts_nanoseconds, payload
    input  logic                        s_tuser,       // op
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [((trw_pkg::SEC_W + trw_pkg::NSEC_W + trw_pkg::OUT_PAY_W + 7) / 8) * 8 - 1:0]
                                        m_tdata,       // out_seconds, out_nanoseconds, out_payload
    output logic [trw_pkg::STATUS_W-1:0] m_tuser       // status
);

    localparam int TS_W       = trw_pkg::SEC_W + trw_pkg::NSEC_W;
    localparam int IN_BITS    = TS_W + PAYLOAD_BITS;
    localparam int OUT_BITS   = TS_W + trw_pkg::OUT_PAY_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int FILL_W     = $clog2(DEPTH + 1);

    logic [trw_pkg::LEN_W-1:0]    len_reg;
    logic [FILL_W-1:0]            fill_reg, fill_next;
    logic                         out_valid_reg;
    logic [trw_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [trw_pkg::SEC_W-1:0]    out_sec_reg, out_sec_next;
    logic [trw_pkg::NSEC_W-1:0]   out_nsec_reg, out_nsec_next;
    logic [trw_pkg::OUT_PAY_W-1:0] out_pay_reg, out_pay_next;

    logic                         accept;
    logic [trw_pkg::SEC_W-1:0]    new_sec;
    logic [trw_pkg::NSEC_W-1:0]   new_nsec;
    logic [PAYLOAD_BITS-1:0]      new_pay;
    logic [FILL_W-1:0]            len_eff;
    logic                         empty, full, drop;
    trw_pkg::cell_ctrl_t          ctrl;
    logic [PAYLOAD_BITS+trw_pkg::OUT_PAY_W-1:0] head_pay_ext;

    logic [DEPTH-1:0]             valid_a, g_a;
    logic [trw_pkg::SEC_W-1:0]    sec_a  [DEPTH];
    logic [trw_pkg::NSEC_W-1:0]   nsec_a [DEPTH];
    logic [PAYLOAD_BITS-1:0]      pay_a  [DEPTH];

    assign new_sec  = s_tdata[trw_pkg::SEC_W-1:0];
    assign new_nsec = s_tdata[TS_W-1:trw_pkg::SEC_W];
    assign new_pay  = s_tdata[IN_BITS-1:TS_W];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        if (len_reg == '0) begin
            len_eff = FILL_W'(1);
        end else if (32'(len_reg) > 32'(DEPTH)) begin
            len_eff = FILL_W'(DEPTH);
        end else begin
            len_eff = FILL_W'(len_reg);
        end
    end

    assign empty = (fill_reg == '0);
    assign full  = (fill_reg >= len_eff);
    assign drop  = !empty && !g_a[0];

    assign ctrl.load = accept && (s_tuser == trw_pkg::OP_INSERT) && !drop;
    assign ctrl.full = full;

    generate
        for (genvar k = 0; k < DEPTH; k++) begin : g_cell
            logic                       g_below, valid_below, g_above;
            logic [trw_pkg::SEC_W-1:0]  up_sec, dn_sec;
            logic [trw_pkg::NSEC_W-1:0] up_nsec, dn_nsec;
            logic [PAYLOAD_BITS-1:0]    up_pay, dn_pay;

            assign valid_a[k] = (FILL_W'(k) < fill_reg);

            if (k == 0) begin : g_first
                assign g_below     = empty;
                assign valid_below = 1'b0;
                assign dn_sec      = new_sec;
                assign dn_nsec     = new_nsec;
                assign dn_pay      = new_pay;
            end else begin : g_mid_lo
                assign g_below     = g_a[k-1];
                assign valid_below = valid_a[k-1];
                assign dn_sec      = sec_a[k-1];
                assign dn_nsec     = nsec_a[k-1];
                assign dn_pay      = pay_a[k-1];
            end

            if (k == DEPTH - 1) begin : g_last
                assign g_above = 1'b0;
                assign up_sec  = new_sec;
                assign up_nsec = new_nsec;
                assign up_pay  = new_pay;
            end else begin : g_mid_hi
                assign g_above = g_a[k+1];
                assign up_sec  = sec_a[k+1];
                assign up_nsec = nsec_a[k+1];
                assign up_pay  = pay_a[k+1];
            end

            trw_cell #(
                .PAYLOAD_BITS(PAYLOAD_BITS)
            ) u_cell (
                .aclk          (aclk),
                .ctrl          (ctrl),
                .valid_i       (valid_a[k]),
                .g_below_i     (g_below),
                .valid_below_i (valid_below),
                .g_above_i     (g_above),
                .new_sec_i     (new_sec),
                .new_nsec_i    (new_nsec),
                .new_pay_i     (new_pay),
                .up_sec_i      (up_sec),
                .up_nsec_i     (up_nsec),
                .up_pay_i      (up_pay),
                .dn_sec_i      (dn_sec),
                .dn_nsec_i     (dn_nsec),
                .dn_pay_i      (dn_pay),
                .g_o           (g_a[k]),
                .sec_o         (sec_a[k]),
                .nsec_o        (nsec_a[k]),
                .pay_o         (pay_a[k])
            );
        end
    endgenerate

    assign head_pay_ext = {{trw_pkg::OUT_PAY_W{1'b0}}, pay_a[0]};

    always_comb begin
        fill_next     = fill_reg;
        status_next   = trw_pkg::STATUS_HELD;
        out_sec_next  = '0;
        out_nsec_next = '0;
        out_pay_next  = '0;
        if (s_tuser == trw_pkg::OP_CLEAR) begin
            fill_next   = '0;
            status_next = trw_pkg::STATUS_CLEARED;
        end else if (empty) begin
            fill_next   = FILL_W'(1);
            status_next = trw_pkg::STATUS_HELD;
        end else if (drop) begin
            status_next = trw_pkg::STATUS_DROPPED;
        end else if (full) begin
            status_next   = trw_pkg::STATUS_EMITTED;
            out_sec_next  = sec_a[0];
            out_nsec_next = nsec_a[0];
            out_pay_next  = head_pay_ext[trw_pkg::OUT_PAY_W-1:0];
        end else begin
            fill_next   = fill_reg + FILL_W'(1);
            status_next = trw_pkg::STATUS_HELD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= trw_pkg::LEN_RESET;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                len_reg <= cfg_wr_data;
            end
            if (accept) begin
                fill_reg      <= fill_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg   <= status_next;
            out_sec_reg  <= out_sec_next;
            out_nsec_reg <= out_nsec_next;
            out_pay_reg  <= out_pay_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = OUT_DATA_W'({out_pay_reg, out_nsec_reg, out_sec_reg});

endmodule
